// ----- rtl/core/lzwd_pkg.sv -----
// lzwd_pkg: shared constants, codes and control types for the LZW decoder.
// No dependencies; imported by lzwd_ctrl, lzwd_dp and the top level.
`timescale 1ns / 1ps
package lzwd_pkg;

   localparam int START_CODE_BITS    = 9;
   localparam int DEF_MAX_CODE_BITS  = 12;
   localparam int DEF_COUNT_BITS     = 24;
   localparam int CLEAR_CODE         = 1 << (START_CODE_BITS - 1);
   localparam int END_CODE           = CLEAR_CODE + 1;
   localparam int FIRST_FREE         = CLEAR_CODE + 2;
   localparam int TOTAL_W            = 24;

   typedef enum logic [1:0] {
      OP_FEED    = 2'd0,
      OP_FETCH   = 2'd1,
      OP_RESTART = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RS_OK      = 2'd0,
      RS_REFUSED = 2'd1,
      RS_ENDED   = 2'd2,
      RS_EMPTY   = 2'd3
   } rsp_status_type;

   typedef enum logic [1:0] {
      PH_NORMAL      = 2'd0,
      PH_AFTER_CLEAR = 2'd1,
      PH_ENDED       = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DECODE,
      CS_WALK,
      CS_FINISH,
      CS_RESP
   } ctl_state_type;

   typedef struct packed {
      logic accept;
      logic dec_start;
      logic walk_step;
      logic finish;
      logic resp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic feed_code;
      logic dec_special;
      logic start_walk;
      logic walk_more;
      logic out_busy;
   } dp_stat_type;

endpackage

// ----- rtl/core/lzwd_ctrl.sv -----
// lzwd_ctrl: sequencer for accept, decode, chain walk, finish and response.
// Depends on lzwd_pkg for the state enum and command/status structs.
`timescale 1ns / 1ps
module lzwd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lzwd_pkg::dp_stat_type stat,
   output lzwd_pkg::ctl_cmd_type cmd
);
   import lzwd_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         CS_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.feed_code ? CS_DECODE : CS_RESP;
            end
         end
         CS_DECODE: begin
            cmd.dec_start = 1'b1;
            if (stat.dec_special) begin
               state_in = CS_RESP;
            end else if (stat.start_walk) begin
               state_in = CS_WALK;
            end else begin
               state_in = CS_FINISH;
            end
         end
         CS_WALK: begin
            cmd.walk_step = 1'b1;
            state_in      = stat.walk_more ? CS_WALK : CS_FINISH;
         end
         CS_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = CS_RESP;
         end
         CS_RESP: begin
            if (!stat.out_busy) begin
               cmd.resp_load = 1'b1;
               state_in      = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/lzwd_dp.sv -----
// lzwd_dp: bit unpacker, dictionary and pending-stack memories, result register.
// Depends on lzwd_pkg; driven by lzwd_ctrl through ctl_cmd_type.
`timescale 1ns / 1ps
module lzwd_dp #(
   parameter int MAX_CODE_BITS = lzwd_pkg::DEF_MAX_CODE_BITS,
   parameter int COUNT_BITS    = lzwd_pkg::DEF_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_opcode,
   input  logic [7:0]            req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic                  rsp_out_valid,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_last,
   output logic                  rsp_ended,
   output logic [23:0]           rsp_total_out,
   input  lzwd_pkg::ctl_cmd_type cmd,
   output lzwd_pkg::dp_stat_type stat
);
   import lzwd_pkg::*;

   localparam int M     = MAX_CODE_BITS;
   localparam int NS_W  = M + 1;
   localparam int ACC_W = M + 8;
   localparam int HW    = $clog2(M + 8);
   localparam int CW_W  = $clog2(M + 1);
   localparam int DEPTH = 1 << M;
   localparam logic [NS_W-1:0] TBL_LESS2 = NS_W'(DEPTH - 2);

   // unpacker and decoder state
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [HW-1:0]    held_ff, held_in;
   logic [CW_W-1:0]  width_ff, width_in;
   logic [NS_W-1:0]  slot_ff, slot_in;
   logic [M-1:0]     last_ff, last_in;
   logic [7:0]       pfb_ff, pfb_in;
   phase_type        phase_ff, phase_in;
   logic [NS_W-1:0]  pend_ff, pend_in;
   logic [COUNT_BITS-1:0] emit_ff, emit_in;

   // per-item working registers
   logic [M-1:0]     code_ff, code_in;
   logic [M-1:0]     walk_ff, walk_in;
   logic [NS_W-1:0]  n_ff, n_in;
   rsp_status_type   res_status_ff, res_status_in;
   logic             res_valid_ff, res_valid_in;
   logic             res_last_ff, res_last_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff;
   logic             rsp_out_valid_ff;
   logic [7:0]       rsp_out_byte_ff;
   logic             rsp_run_last_ff;
   logic             rsp_ended_ff;
   logic [23:0]      rsp_total_ff;

   // memories
   logic [M-1:0] prefix_mem [DEPTH];
   logic [7:0]   suffix_mem [DEPTH];
   logic [7:0]   stack_mem  [DEPTH];
   logic [M-1:0] prefix_q;
   logic [7:0]   suffix_q;
   logic [7:0]   stack_q;

   logic         dict_re, dict_we, stk_re, stk_we;
   logic [M-1:0] dict_ra, dict_wa, stk_ra, stk_wa;
   logic [7:0]   stk_wd;

   op_type           op;
   logic [ACC_W-1:0] acc_sum, code_mask;
   logic [HW-1:0]    held_sum;
   logic             code_ready;
   logic [M-1:0]     walk_init, code_clip;
   logic             prev_rule, is_clear, is_end;
   logic [NS_W-1:0]  slot_lim, slot_new;
   logic             room;

   always_comb begin
      op        = op_type'(req_opcode);
      acc_sum   = acc_ff | (ACC_W'(req_in_byte) << held_ff);
      held_sum  = held_ff + HW'(8);
      code_ready = (held_sum >= HW'(width_ff));
      code_mask = (ACC_W'(1) << width_ff) - ACC_W'(1);
      is_clear  = (code_ff == M'(CLEAR_CODE));
      is_end    = (code_ff == M'(END_CODE));
      prev_rule = ({1'b0, code_ff} >= slot_ff);
      walk_init = prev_rule ? last_ff : code_ff;
      code_clip = (code_ff >= M'(FIRST_FREE)) ? '0 : code_ff;
      slot_lim  = NS_W'(1) << width_ff;
      room      = (slot_ff < slot_lim);
      slot_new  = room ? slot_ff + NS_W'(1) : slot_ff;

      stat.feed_code   = (op == OP_FEED) && (phase_ff != PH_ENDED) &&
                         (pend_ff == '0) && code_ready;
      stat.dec_special = (phase_ff == PH_AFTER_CLEAR) || is_clear || is_end;
      stat.start_walk  = (walk_init >= M'(FIRST_FREE));
      stat.walk_more   = (prefix_q >= M'(FIRST_FREE)) && (n_ff < TBL_LESS2);
      stat.out_busy    = rsp_valid_ff && rsp_stall;
   end

   // memory port selection
   always_comb begin
      dict_re = 1'b0;
      dict_ra = walk_init;
      if (cmd.dec_start && !stat.dec_special && stat.start_walk) begin
         dict_re = 1'b1;
      end else if (cmd.walk_step && stat.walk_more) begin
         dict_re = 1'b1;
         dict_ra = prefix_q;
      end
      dict_we = cmd.finish && room;
      dict_wa = slot_ff[M-1:0];

      stk_re = cmd.accept && (op == OP_FETCH) && (pend_ff != '0);
      stk_ra = M'(pend_ff - NS_W'(1));

      stk_we = 1'b0;
      stk_wa = n_ff[M-1:0];
      stk_wd = walk_ff[7:0];
      if (cmd.dec_start) begin
         stk_wa = '0;
         if (phase_ff == PH_AFTER_CLEAR) begin
            stk_we = !is_clear && !is_end;
            stk_wd = code_clip[7:0];
         end else begin
            stk_we = !is_clear && !is_end && prev_rule;
            stk_wd = pfb_ff;
         end
      end else if (cmd.walk_step) begin
         stk_we = 1'b1;
         stk_wd = suffix_q;
      end else if (cmd.finish) begin
         stk_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dict_we) begin
         prefix_mem[dict_wa] <= last_ff;
         suffix_mem[dict_wa] <= walk_ff[7:0];
      end
      if (dict_re) begin
         prefix_q <= prefix_mem[dict_ra];
         suffix_q <= suffix_mem[dict_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_wa] <= stk_wd;
      end
      if (stk_re) begin
         stack_q <= stack_mem[stk_ra];
      end
   end

   // next state of the decoder
   always_comb begin
      acc_in    = acc_ff;
      held_in   = held_ff;
      width_in  = width_ff;
      slot_in   = slot_ff;
      last_in   = last_ff;
      pfb_in    = pfb_ff;
      phase_in  = phase_ff;
      pend_in   = pend_ff;
      emit_in   = emit_ff;
      code_in   = code_ff;
      walk_in   = walk_ff;
      n_in      = n_ff;
      res_status_in = res_status_ff;
      res_valid_in  = res_valid_ff;
      res_last_in   = res_last_ff;

      if (cmd.accept) begin
         res_status_in = RS_OK;
         res_valid_in  = 1'b0;
         res_last_in   = 1'b0;
         case (op)
            OP_FEED: begin
               if (phase_ff == PH_ENDED) begin
                  res_status_in = RS_ENDED;
               end else if (pend_ff != '0) begin
                  res_status_in = RS_REFUSED;
               end else if (code_ready) begin
                  code_in = M'(acc_sum & code_mask);
                  acc_in  = acc_sum >> width_ff;
                  held_in = held_sum - HW'(width_ff);
               end else begin
                  acc_in  = acc_sum;
                  held_in = held_sum;
               end
            end
            OP_FETCH: begin
               if (pend_ff == '0) begin
                  res_status_in = RS_EMPTY;
               end else begin
                  pend_in      = pend_ff - NS_W'(1);
                  res_valid_in = 1'b1;
                  res_last_in  = (pend_ff == NS_W'(1));
                  if (emit_ff != '1) begin
                     emit_in = emit_ff + COUNT_BITS'(1);
                  end
               end
            end
            OP_RESTART: begin
               acc_in   = '0;
               held_in  = '0;
               width_in = CW_W'(START_CODE_BITS);
               slot_in  = NS_W'(FIRST_FREE);
               last_in  = '0;
               pfb_in   = '0;
               phase_in = PH_NORMAL;
               pend_in  = '0;
               emit_in  = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.dec_start) begin
         if (phase_ff == PH_AFTER_CLEAR) begin
            if (is_end) begin
               phase_in = PH_ENDED;
            end else if (!is_clear) begin
               last_in  = code_clip;
               pfb_in   = code_clip[7:0];
               pend_in  = NS_W'(1);
               phase_in = PH_NORMAL;
            end
         end else if (is_clear) begin
            slot_in  = NS_W'(FIRST_FREE);
            width_in = CW_W'(START_CODE_BITS);
            phase_in = PH_AFTER_CLEAR;
         end else if (is_end) begin
            phase_in = PH_ENDED;
         end else begin
            walk_in = walk_init;
            n_in    = prev_rule ? NS_W'(1) : '0;
         end
      end

      if (cmd.walk_step) begin
         walk_in = prefix_q;
         n_in    = n_ff + NS_W'(1);
      end

      if (cmd.finish) begin
         pend_in = n_ff + NS_W'(1);
         slot_in = slot_new;
         if (room) begin
            pfb_in  = walk_ff[7:0];
            last_in = code_ff;
         end
         if (slot_new >= slot_lim && width_ff < CW_W'(M)) begin
            width_in = width_ff + CW_W'(1);
         end
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.resp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         held_ff      <= '0;
         width_ff     <= CW_W'(START_CODE_BITS);
         slot_ff      <= NS_W'(FIRST_FREE);
         last_ff      <= '0;
         pfb_ff       <= '0;
         phase_ff     <= PH_NORMAL;
         pend_ff      <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         held_ff      <= held_in;
         width_ff     <= width_in;
         slot_ff      <= slot_in;
         last_ff      <= last_in;
         pfb_ff       <= pfb_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      walk_ff       <= walk_in;
      n_ff          <= n_in;
      res_status_ff <= res_status_in;
      res_valid_ff  <= res_valid_in;
      res_last_ff   <= res_last_in;
      if (cmd.resp_load) begin
         rsp_status_ff    <= res_status_ff;
         rsp_out_valid_ff <= res_valid_ff;
         rsp_out_byte_ff  <= res_valid_ff ? stack_q : 8'd0;
         rsp_run_last_ff  <= res_last_ff;
         rsp_ended_ff     <= (phase_ff == PH_ENDED);
         rsp_total_ff     <= TOTAL_W'(emit_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_run_last  = rsp_run_last_ff;
   assign rsp_ended     = rsp_ended_ff;
   assign rsp_total_out = rsp_total_ff;

   a_walk_dict_code: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> walk_ff >= M'(FIRST_FREE))
      else $error("chain walk on a literal code");

   a_held_below_width: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> held_ff < HW'(width_ff))
      else $error("unpacker holds a whole code between items");

   a_width_range: assert property (@(posedge clock) disable iff (reset)
      width_ff >= CW_W'(START_CODE_BITS) && width_ff <= CW_W'(M))
      else $error("code width out of range");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= NS_W'(DEPTH))
      else $error("pending string longer than the stack");

endmodule

// ----- rtl/core/lzw_variable_width_decoder.sv -----
// Top level of the LZW variable-width decoder: controller plus datapath.
// Depends on lzwd_pkg, lzwd_ctrl and lzwd_dp.
// Sequence: fetch, restart, no-op and a feed that completes no code go from accept
//   to the response state; a clear, an end or the first code after a clear pass through
//   decode first; any other code runs decode, a walk over L entries (one per cycle
//   through the dictionary RAM), finish and response. One item at a time: the next item
//   is taken once the previous one reaches the output register.
// Reset: synchronous, active high; clears unpacker, decoder and counters; RAMs untouched.
`timescale 1ns / 1ps
module lzw_variable_width_decoder #(
   parameter int MAX_CODE_BITS = lzwd_pkg::DEF_MAX_CODE_BITS,
   parameter int COUNT_BITS    = lzwd_pkg::DEF_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_ended,
   output logic [23:0] rsp_total_out
);
   import lzwd_pkg::*;

   // command and status between the sequencer and the datapath
   ctl_cmd_type cmd;
   dp_stat_type stat;

   // sequencer: take an item, decode a completed code, walk the chain, respond
   lzwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: bit unpacker, dictionary RAMs, pending-byte stack, output register
   lzwd_dp #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_opcode    (req_opcode),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_ended     (rsp_ended),
      .rsp_total_out (rsp_total_out),
      .cmd           (cmd),
      .stat          (stat)
   );

endmodule

// ----- dv/lzw_variable_width_decoder_tb.sv -----
// Self-checking testbench for lzw_variable_width_decoder: LZW code streams are built,
// packed LSB first and predicted item by item. Depends on lzwd_pkg and the RTL top.
`timescale 1ns / 1ps
module lzw_variable_width_decoder_tb;
   import lzwd_pkg::*;

   localparam int TBL        = 4096;
   localparam int MAX_W      = 12;
   localparam int IDLE_LIMIT = 20000;
   localparam int LONG_HOLD  = 400;

   typedef struct {
      op_type     op;
      logic [7:0] data;
   } req_item_type;

   typedef struct {
      rsp_status_type st;
      logic           ov;
      logic [7:0]     ob;
      logic           rl;
      logic           en;
      logic [23:0]    tot;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_NOP;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_out_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_ended;
   logic [23:0] rsp_total_out;

   req_item_type pending_items[$];
   rsp_item_type expected_rsps[$];
   int           errors = 0;

   lzw_variable_width_decoder uut (.*);

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Decoder predictor: its own copy of the unpacker, dictionary and output stack.
   // ---------------------------------------------------------------------------
   logic [31:0] p_acc;
   int          p_held, p_width, p_slot, p_pend;
   logic [11:0] p_last;
   logic [7:0]  p_first;
   phase_type   p_phase;
   logic [11:0] p_prefix [TBL];
   logic [7:0]  p_suffix [TBL];
   logic [7:0]  p_stack  [TBL];
   logic [23:0] p_total;

   function automatic void predictor_clear();
      p_acc = 0; p_held = 0; p_width = START_CODE_BITS; p_slot = FIRST_FREE;
      p_last = 0; p_first = 0; p_phase = PH_NORMAL; p_pend = 0; p_total = 0;
   endfunction

   function automatic void predict_code(int code);
      int         walk;
      int         n;
      logic [7:0] first;
      n = 0;
      if (p_phase == PH_AFTER_CLEAR) begin
         if (code == CLEAR_CODE) return;
         if (code == END_CODE) begin
            p_phase = PH_ENDED;
            return;
         end
         if (code >= FIRST_FREE) code = 0;
         p_last = code; p_first = code[7:0]; p_stack[0] = code[7:0];
         p_pend = 1; p_phase = PH_NORMAL;
         return;
      end
      if (code == CLEAR_CODE) begin
         p_slot = FIRST_FREE; p_width = START_CODE_BITS; p_phase = PH_AFTER_CLEAR;
         return;
      end
      if (code == END_CODE) begin
         p_phase = PH_ENDED;
         return;
      end
      walk = code;
      // code not yet in the table: previous string plus its own first byte
      if (code >= p_slot) begin
         walk = p_last;
         p_stack[n++] = p_first;
      end
      while (walk >= FIRST_FREE && n < TBL - 1) begin
         p_stack[n++] = p_suffix[walk % TBL];
         walk = p_prefix[walk % TBL];
      end
      first = walk[7:0];
      p_stack[n++] = first;
      if (p_slot < (1 << p_width)) begin
         p_suffix[p_slot % TBL] = first;
         p_prefix[p_slot % TBL] = p_last;
         p_first = first; p_last = code;
         p_slot++;
      end
      if (p_slot >= (1 << p_width) && p_width < MAX_W) p_width++;
      p_pend = n;
   endfunction

   function automatic rsp_item_type predict_item(req_item_type it);
      rsp_item_type r;
      int           code;
      r = '{RS_OK, 1'b0, 8'd0, 1'b0, 1'b0, 24'd0};
      case (it.op)
         OP_FEED: begin
            if (p_phase == PH_ENDED) r.st = RS_ENDED;
            else if (p_pend > 0) r.st = RS_REFUSED;
            else begin
               p_acc |= 32'(it.data) << p_held;
               p_held += 8;
               if (p_held >= p_width) begin
                  code = p_acc & ((1 << p_width) - 1);
                  p_acc >>= p_width;
                  p_held -= p_width;
                  predict_code(code);
               end
            end
         end
         OP_FETCH: begin
            if (p_pend == 0) r.st = RS_EMPTY;
            else begin
               p_pend--;
               r.ob = p_stack[p_pend]; r.ov = 1'b1; r.rl = (p_pend == 0);
               if (p_total != 24'hFFFFFF) p_total++;
            end
         end
         OP_RESTART: predictor_clear();
         default: ;
      endcase
      r.en = (p_phase == PH_ENDED);
      r.tot = p_total;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Stream builder: a shadow of width, free slot and phase picks legal codes.
   // ---------------------------------------------------------------------------
   bit        code_bits[$];
   int        s_width, s_slot;
   phase_type s_phase;

   task automatic issue(op_type op, logic [7:0] data);
      req_item_type it;
      it = '{op, data};
      pending_items.push_back(it);
      expected_rsps.push_back(predict_item(it));
   endtask

   // Fetch everything that is pending, with the odd refused feed or no-op mixed in.
   task automatic drain_output();
      while (p_pend > 0) begin
         case ($urandom_range(0, 15))
            0: issue(OP_FEED, 8'($urandom));
            1: issue(OP_NOP, 8'($urandom));
            default: issue(OP_FETCH, 8'($urandom));
         endcase
      end
   endtask

   task automatic push_bytes();
      logic [7:0] b;
      while (code_bits.size() >= 8) begin
         for (int i = 0; i < 8; i++) b[i] = code_bits.pop_front();
         issue(OP_FEED, b);
         drain_output();
      end
   endtask

   task automatic send_code(int code);
      for (int i = 0; i < s_width; i++) code_bits.push_back(code[i]);
      if (s_phase == PH_AFTER_CLEAR) begin
         if (code == END_CODE) s_phase = PH_ENDED;
         else if (code != CLEAR_CODE) s_phase = PH_NORMAL;
      end else if (code == CLEAR_CODE) begin
         s_width = START_CODE_BITS; s_slot = FIRST_FREE; s_phase = PH_AFTER_CLEAR;
      end else if (code == END_CODE) begin
         s_phase = PH_ENDED;
      end else begin
         if (s_slot < (1 << s_width)) s_slot++;
         if (s_slot >= (1 << s_width) && s_width < MAX_W) s_width++;
      end
      push_bytes();
   endtask

   task automatic restart_stream();
      issue(OP_RESTART, 8'($urandom));
      code_bits.delete();
      s_width = START_CODE_BITS; s_slot = FIRST_FREE; s_phase = PH_NORMAL;
   endtask

   // Close the stream: end code, pad to a byte, then poke the ended decoder.
   task automatic end_stream();
      send_code(END_CODE);
      while (code_bits.size() % 8 != 0) code_bits.push_back($urandom_range(0, 1));
      push_bytes();
      issue(OP_FEED, 8'($urandom));
      issue(OP_FETCH, 8'($urandom));
   endtask

   // Random legal code; literal_pct sets how often a plain byte is chosen.
   function automatic int pick_code(int literal_pct);
      int r;
      r = $urandom_range(0, 99);
      if (s_phase == PH_AFTER_CLEAR) begin
         if (r < 10) return CLEAR_CODE;
         if (r < 25) return $urandom_range(FIRST_FREE, (1 << s_width) - 1);
         return $urandom_range(0, 255);
      end
      if (r < 2) return CLEAR_CODE;
      if (r < literal_pct || s_slot == FIRST_FREE) begin
         if (s_slot < TBL && $urandom_range(0, 7) == 0) return s_slot;
         return $urandom_range(0, 255);
      end
      if (s_slot < TBL && $urandom_range(0, 5) == 0) return s_slot;
      return $urandom_range(FIRST_FREE, s_slot - 1);
   endfunction

   task automatic random_stream(int n_codes, int literal_pct, bit lead_clear, bit close);
      restart_stream();
      if (lead_clear) send_code(CLEAR_CODE);
      repeat (n_codes) send_code(pick_code(literal_pct));
      if (close) end_stream();
   endtask

   initial begin
      predictor_clear();
      // Directed: empty fetch, no-op, stream with no leading clear, new-code case,
      // repeated clears, large code after clear, end and items after the end.
      restart_stream();
      issue(OP_FETCH, 8'hFF);
      issue(OP_NOP, 8'h00);
      send_code(65);
      send_code(FIRST_FREE);
      send_code(FIRST_FREE + 1);
      send_code(CLEAR_CODE);
      send_code(CLEAR_CODE);
      send_code(511);
      send_code(255);
      send_code(FIRST_FREE);
      send_code(0);
      send_code(FIRST_FREE + 1);
      end_stream();
      // Random: short streams, some left open, some with a richer chain mix.
      for (int k = 0; k < 6; k++)
         random_stream($urandom_range(8, 16), 60, $urandom_range(0, 1), k % 4 != 3);
      for (int k = 0; k < 2; k++) random_stream($urandom_range(8, 16), 40, 1'b0, 1'b1);
   end

   // ---------------------------------------------------------------------------
   // Driver: present queued items, hold while stalled, idle a random gap per item.
   // ---------------------------------------------------------------------------
   int send_gap = 0;

   always @(posedge clock) begin
      req_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (req_valid && req_stall) begin
         // hold the stalled item
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
         it = pending_items.pop_front();
         req_valid <= 1'b1;
         req_opcode <= it.op;
         req_in_byte <= it.data;
         send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: check each accepted result against the oldest expectation and
   // draw the stall for the next one; once, hold off long so the input backs up.
   // ---------------------------------------------------------------------------
   int hold_left = 0;
   int rsp_count = 0;

   always @(posedge clock) begin
      rsp_item_type e;
      int           w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("result with no expectation waiting");
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.st) begin
               $error("status: expected %0d, got %0d", e.st, rsp_status); errors++;
            end
            if (rsp_out_valid !== e.ov) begin
               $error("out_valid: expected %0d, got %0d", e.ov, rsp_out_valid); errors++;
            end
            if (rsp_out_byte !== e.ob) begin
               $error("out_byte: expected %0h, got %0h", e.ob, rsp_out_byte); errors++;
            end
            if (rsp_run_last !== e.rl) begin
               $error("run_last: expected %0d, got %0d", e.rl, rsp_run_last); errors++;
            end
            if (rsp_ended !== e.en) begin
               $error("ended: expected %0d, got %0d", e.en, rsp_ended); errors++;
            end
            if (rsp_total_out !== e.tot) begin
               $error("total_out: expected %0d, got %0d", e.tot, rsp_total_out); errors++;
            end
         end
         rsp_count <= rsp_count + 1;
         if (rsp_count == 150) w = LONG_HOLD;
         else w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
         rsp_stall <= (w > 0);
         hold_left <= (w > 0) ? w - 1 : 0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: count cycles in which neither side moves an item.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      // let any stray result show up before judging
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
